// ===== hdl/f2s_pkg.sv =====
// Package for the frame-to-spike event encoder.
// Holds field widths, register indexes, reset values and the shared structs.
// Depends on nothing.
package f2s_pkg;

	localparam int FRAME_W  = 16;
	localparam int CHAN_W   = 2;
	localparam int PIX_W    = 12;
	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 15;
	localparam int PERIOD_W = 24;
	localparam int ACC_W    = 24;
	localparam int TS_W     = 40;
	localparam int CNT_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [THR_W-1:0]    THR_RESET    = 15'd410;
	localparam logic                DIFF_RESET   = 1'b1;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd33333;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_ACC_DIFF   = 2'd1,
		REG_FRAME_PER  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]    thr;
		logic                diff;
		logic [PERIOD_W-1:0] period;
	} cfg_t;

	// One burst of events handed from the front end to the back end.
	typedef struct packed {
		logic [TS_W-1:0]   base;
		logic [ACC_W-1:0]  value;
		logic [CNT_W-1:0]  count;
		logic [CHAN_W-1:0] chan;
		logic [PIX_W-1:0]  pix;
	} job_t;

endpackage

// ===== hdl/f2s_if.sv =====
// Channel interfaces of the frame-to-spike event encoder.
// Depends on f2s_pkg for the field widths.
interface f2s_pixel_if import f2s_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [FRAME_W-1:0]         frame_number;
	logic [CHAN_W-1:0]          channel;
	logic [PIX_W-1:0]           pixel_index;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       negated;
	logic [CHAN_W-1:0]          partner_channel;

	modport source (output valid, frame_number, channel, pixel_index, sample_value,
		negated, partner_channel, input ready);
	modport sink (input valid, frame_number, channel, pixel_index, sample_value,
		negated, partner_channel, output ready);
endinterface

interface f2s_spike_if import f2s_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TS_W-1:0]   timestamp;
	logic [CHAN_W-1:0] event_channel;
	logic [PIX_W-1:0]  event_pixel;
	logic              last;

	modport source (output valid, timestamp, event_channel, event_pixel, last, input ready);
	modport sink (input valid, timestamp, event_channel, event_pixel, last, output ready);
endinterface

// ===== hdl/f2s_front.sv =====
// Front end: accepts pixel beats, updates the accumulator and previous-sample
// memories and works out how many events each beat causes. Uses f2s_pkg.
module f2s_front import f2s_pkg::*; #(
	parameter int PIXELS     = 4096,
	parameter int CHANNELS   = 4,
	parameter int MAX_EVENTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cfg_t           cfg,
	f2s_pixel_if.sink      pixel,
	output job_t           job,
	output logic           job_push,
	input  logic           job_full
);

	localparam int DEPTH = CHANNELS * PIXELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW    = $clog2(MAX_EVENTS + 1);
	localparam int BW    = (QW > 1) ? $clog2(QW) : 1;
	localparam int CAP_W = THR_W + CNT_W;
	localparam int NT_W  = THR_W + CNT_W;
	localparam int V_W   = ACC_W + 1;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_UPD, ST_RDACC, ST_CHK, ST_DIV, ST_MUL, ST_WB, ST_PUSH
	} state_t;

	state_t                      state_q;
	logic [AW-1:0]               clr_q;
	logic [FRAME_W-1:0]          frame_q;
	logic [CHAN_W-1:0]           chan_q;
	logic [PIX_W-1:0]            pix_q;
	logic signed [SAMPLE_W-1:0]  sample_q;
	logic                        neg_q;
	logic [AW-1:0]               own_q;
	logic [AW-1:0]               idx_q;
	logic signed [V_W-1:0]       v_q;
	logic [V_W-1:0]              rem_q;
	logic [CNT_W-1:0]            quo_q;
	logic [BW-1:0]               bit_q;
	logic [NT_W-1:0]             nt_q;
	logic [TS_W-1:0]             base_q;

	logic signed [ACC_W-1:0]     acc_mem [DEPTH];
	logic signed [SAMPLE_W-1:0]  prev_mem [DEPTH];
	logic signed [ACC_W-1:0]     acc_rd_q;
	logic signed [SAMPLE_W-1:0]  prev_rd_q;

	logic                        acc_we, acc_re, prev_we, prev_re;
	logic [AW-1:0]               acc_wa, acc_ra, prev_wa, prev_ra;
	logic signed [ACC_W-1:0]     acc_wd;
	logic signed [SAMPLE_W-1:0]  prev_wd;

	logic                        accept, item_ok;
	logic [AW-1:0]               own_d, idx_d;
	logic signed [SAMPLE_W:0]    add_d;
	logic signed [V_W-1:0]       sum_d;
	logic signed [ACC_W-1:0]     sat_d;
	logic signed [V_W-1:0]       v_d;
	logic signed [V_W-1:0]       thr_s;
	logic signed [V_W-1:0]       cap_s;
	logic [V_W-1:0]              tsh_d;
	logic signed [ACC_W-1:0]     cur_new_d;

	// Beat classification and memory addresses.
	assign pixel.ready = (state_q == ST_IDLE);
	assign accept  = pixel.valid && pixel.ready;
	assign item_ok = (int'(pixel.channel) < CHANNELS) && (int'(pixel.pixel_index) < PIXELS) &&
		(!pixel.negated || (int'(pixel.partner_channel) < CHANNELS));
	assign own_d = AW'(AW'(pixel.channel) * AW'(PIXELS) + AW'(pixel.pixel_index));
	assign idx_d = AW'(AW'(pixel.negated ? pixel.partner_channel : pixel.channel) *
		AW'(PIXELS) + AW'(pixel.pixel_index));

	// Saturating accumulate of the sample or of its frame difference.
	assign add_d = cfg.diff ? ((SAMPLE_W+1)'(sample_q) - (SAMPLE_W+1)'(prev_rd_q))
		: (SAMPLE_W+1)'(sample_q);
	assign sum_d = V_W'(acc_rd_q) + V_W'(add_d);
	assign sat_d = (sum_d[V_W-1] != sum_d[V_W-2]) ?
		(sum_d[V_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
		sum_d[ACC_W-1:0];

	// Accumulator read with the channel's sign, and the event-count bounds.
	assign v_d   = neg_q ? -V_W'(acc_rd_q) : V_W'(acc_rd_q);
	assign thr_s = $signed(V_W'(cfg.thr));
	assign cap_s = $signed(V_W'(CAP_W'(cfg.thr) * CAP_W'(MAX_EVENTS)));
	assign tsh_d = V_W'(cfg.thr) << bit_q;
	assign cur_new_d = neg_q ? (acc_rd_q + ACC_W'(nt_q)) : (acc_rd_q - ACC_W'(nt_q));

	// Memory port control.
	always_comb begin
		acc_we  = 1'b0;
		acc_re  = 1'b0;
		prev_we = 1'b0;
		prev_re = 1'b0;
		acc_wa  = own_q;
		acc_ra  = own_d;
		prev_wa = own_q;
		prev_ra = own_d;
		acc_wd  = sat_d;
		prev_wd = sample_q;
		unique case (state_q)
			ST_CLR: begin
				acc_we  = 1'b1;
				prev_we = 1'b1;
				acc_wa  = clr_q;
				prev_wa = clr_q;
				acc_wd  = '0;
				prev_wd = '0;
			end
			ST_IDLE: begin
				acc_re  = accept && item_ok;
				prev_re = accept && item_ok;
			end
			ST_UPD: begin
				prev_we = !neg_q;
				acc_we  = !neg_q && (frame_q != '0);
			end
			ST_RDACC: begin
				acc_re = 1'b1;
				acc_ra = idx_q;
			end
			ST_WB: begin
				acc_we = 1'b1;
				acc_wa = idx_q;
				acc_wd = cur_new_d;
			end
			default: begin
			end
		endcase
	end

	// Accumulator and previous-sample memories with registered reads.
	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[acc_wa] <= acc_wd;
		if (acc_re)
			acc_rd_q <= acc_mem[acc_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we)
			prev_mem[prev_wa] <= prev_wd;
		if (prev_re)
			prev_rd_q <= prev_mem[prev_ra];
	end

	// Sequencer for one pixel beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			frame_q  <= '0;
			chan_q   <= '0;
			pix_q    <= '0;
			sample_q <= '0;
			neg_q    <= 1'b0;
			own_q    <= '0;
			idx_q    <= '0;
			v_q      <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			bit_q    <= '0;
			nt_q     <= '0;
			base_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && item_ok) begin
						frame_q  <= pixel.frame_number;
						chan_q   <= pixel.channel;
						pix_q    <= pixel.pixel_index;
						sample_q <= pixel.sample_value;
						neg_q    <= pixel.negated;
						own_q    <= own_d;
						idx_q    <= idx_d;
						state_q  <= ST_UPD;
					end
				end
				ST_UPD: begin
					if ((frame_q == '0) || (cfg.thr == '0))
						state_q <= ST_IDLE;
					else
						state_q <= ST_RDACC;
				end
				ST_RDACC: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					v_q <= v_d;
					if (v_d < thr_s) begin
						state_q <= ST_IDLE;
					end else if (v_d >= cap_s) begin
						quo_q   <= CNT_W'(MAX_EVENTS);
						state_q <= ST_MUL;
					end else begin
						rem_q   <= V_W'(v_d);
						quo_q   <= '0;
						bit_q   <= BW'(QW - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// One quotient bit per cycle: events below the cap.
					if (rem_q >= tsh_d) begin
						rem_q <= rem_q - tsh_d;
						quo_q <= quo_q | (CNT_W'(1) << bit_q);
					end
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					nt_q    <= NT_W'(quo_q) * NT_W'(cfg.thr);
					base_q  <= TS_W'(frame_q - FRAME_W'(1)) * TS_W'(cfg.period);
					state_q <= ST_WB;
				end
				ST_WB: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!job_full)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Burst handed to the back end.
	assign job_push   = (state_q == ST_PUSH) && !job_full;
	assign job.base   = base_q;
	assign job.value  = v_q[ACC_W-1:0];
	assign job.count  = quo_q;
	assign job.chan   = chan_q;
	assign job.pix    = pix_q;

endmodule

// ===== hdl/f2s_queue.sv =====
// Two-entry queue of event bursts between the front and back ends.
// Uses job_t from f2s_pkg.
module f2s_queue import f2s_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic push,
	output logic full,
	output job_t rd_job,
	output logic rd_valid,
	input  logic pop
);

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/f2s_back.sv =====
// Back end: turns one burst into events with interpolated timestamps.
// One divide per burst, then one event per cycle unless stalled. Uses f2s_pkg.
module f2s_back import f2s_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  job_t        job,
	input  logic        job_valid,
	output logic        job_pop,
	f2s_spike_if.source spike
);

	localparam int TP_W = THR_W + PERIOD_W;

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_EMIT} state_t;

	state_t              state_q;
	logic [TP_W-1:0]     tp_q;
	logic [TS_W-1:0]     base_q;
	logic [ACC_W-1:0]    v_q;
	logic [CNT_W-1:0]    n_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [PIX_W-1:0]    pix_q;
	logic [ACC_W-1:0]    rem_q;
	logic [ACC_W-1:0]    dvd_q;
	logic [ACC_W-1:0]    q0_q;
	logic [4:0]          step_q;
	logic [TS_W-1:0]     qa_q;
	logic [ACC_W-1:0]    ra_q;
	logic                o_valid_q;
	logic [TS_W-1:0]     o_ts_q;
	logic [CHAN_W-1:0]   o_chan_q;
	logic [PIX_W-1:0]    o_pix_q;
	logic                o_last_q;

	logic [ACC_W:0]      trial_d;
	logic                ge_d;
	logic [ACC_W:0]      rsum_d;
	logic                carry_d;
	logic [TS_W-1:0]     qa_next_d;
	logic                load_d;

	assign job_pop = (state_q == B_IDLE) && job_valid;

	// Long division step of threshold*period by the accumulator value.
	assign trial_d = {rem_q, dvd_q[ACC_W-1]};
	assign ge_d    = trial_d >= {1'b0, v_q};

	// Running quotient and remainder of i*threshold*period over the value.
	assign rsum_d    = (ACC_W+1)'(ra_q) + (ACC_W+1)'(rem_q);
	assign carry_d   = rsum_d >= {1'b0, v_q};
	assign qa_next_d = qa_q + TS_W'(q0_q) + TS_W'(carry_d);
	assign load_d    = (state_q == B_EMIT) && (!o_valid_q || spike.ready);

	// Threshold*period product; the user must keep config steady while busy.
	always_ff @(posedge clk) begin
		tp_q <= TP_W'(cfg.thr) * TP_W'(cfg.period);
	end

	// Burst sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			base_q    <= '0;
			v_q       <= '0;
			n_q       <= '0;
			chan_q    <= '0;
			pix_q     <= '0;
			rem_q     <= '0;
			dvd_q     <= '0;
			q0_q      <= '0;
			step_q    <= '0;
			qa_q      <= '0;
			ra_q      <= '0;
			o_valid_q <= 1'b0;
			o_ts_q    <= '0;
			o_chan_q  <= '0;
			o_pix_q   <= '0;
			o_last_q  <= 1'b0;
		end else begin
			// The output beat is refilled when load_d is set, else emptied when it is taken.
			if (load_d)
				o_valid_q <= 1'b1;
			else if (spike.ready)
				o_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						base_q  <= job.base;
						v_q     <= job.value;
						n_q     <= job.count;
						chan_q  <= job.chan;
						pix_q   <= job.pix;
						rem_q   <= ACC_W'(tp_q[TP_W-1:ACC_W]);
						dvd_q   <= tp_q[ACC_W-1:0];
						q0_q    <= '0;
						step_q  <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					rem_q  <= ge_d ? ACC_W'(trial_d - {1'b0, v_q}) : trial_d[ACC_W-1:0];
					q0_q   <= {q0_q[ACC_W-2:0], ge_d};
					dvd_q  <= {dvd_q[ACC_W-2:0], 1'b0};
					step_q <= step_q + 5'd1;
					if (step_q == 5'(ACC_W - 1)) begin
						qa_q    <= '0;
						ra_q    <= '0;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (load_d) begin
						ra_q      <= carry_d ? ACC_W'(rsum_d - {1'b0, v_q}) : rsum_d[ACC_W-1:0];
						qa_q      <= qa_next_d;
						o_ts_q    <= base_q + qa_next_d;
						o_chan_q  <= chan_q;
						o_pix_q   <= pix_q;
						o_last_q  <= (n_q == CNT_W'(1));
						n_q       <= n_q - CNT_W'(1);
						if (n_q == CNT_W'(1))
							state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign spike.valid         = o_valid_q;
	assign spike.timestamp     = o_ts_q;
	assign spike.event_channel = o_chan_q;
	assign spike.event_pixel   = o_pix_q;
	assign spike.last          = o_last_q;

endmodule

// ===== hdl/frame_to_spike_event_encoder.sv =====
// Frame-to-spike event encoder, top level.
// Instantiates f2s_front, f2s_queue and f2s_back; uses f2s_pkg and f2s_if.
//
// Usage: a pixel beat carries one filtered Q3.12 sample with frame number,
// channel and pixel index; a spike beat is one event with a 40-bit timestamp,
// and last marks the final event of a pixel beat. The user must write
// registers on the cfg port while idle; the block itself does not enforce it.
// A pixel beat that causes events holds the front end through update,
// accumulator read, check, multiply, write-back and push, plus a divide
// (one quotient bit a cycle) when the event count is below the cap. A beat
// that only records leaves after update, one that causes no event after
// check, and an ignored beat is dropped in idle. The back end divides once
// per burst (one bit a cycle), then emits one event a cycle unless stalled.
// A two-entry burst queue lets the front end keep working while events drain.
// Reset: after arst_n releases, both memories are cleared one entry a cycle,
// with pixel.ready low; cfg writes are taken anyway.
// Stall: when spike.ready is low the held event stays on the port, the back
// end stops, and once the queue fills the front end holds pixel.ready low.
module frame_to_spike_event_encoder import f2s_pkg::*; #(
	parameter int PIXELS     = 4096,
	parameter int CHANNELS   = 4,
	parameter int MAX_EVENTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	f2s_pixel_if.sink             pixel,
	f2s_spike_if.source           spike,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	job_t push_job;
	job_t pop_job;
	logic push;
	logic full;
	logic pop;
	logic pop_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr    <= THR_RESET;
			cfg_q.diff   <= DIFF_RESET;
			cfg_q.period <= PERIOD_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THRESHOLD: cfg_q.thr    <= cfg_data[THR_W-1:0];
				REG_ACC_DIFF:  cfg_q.diff   <= cfg_data[0];
				REG_FRAME_PER: cfg_q.period <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	f2s_front #(
		.PIXELS     (PIXELS),
		.CHANNELS   (CHANNELS),
		.MAX_EVENTS (MAX_EVENTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pixel    (pixel),
		.job      (push_job),
		.job_push (push),
		.job_full (full)
	);

	f2s_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_job   (push_job),
		.push     (push),
		.full     (full),
		.rd_job   (pop_job),
		.rd_valid (pop_valid),
		.pop      (pop)
	);

	f2s_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (pop_job),
		.job_valid (pop_valid),
		.job_pop   (pop),
		.spike     (spike)
	);

endmodule

// ===== hdl/f2s_checker.sv =====
// Port-level checks for the frame-to-spike event encoder, bound to the top.
// Depends on f2s_pkg for the timestamp width.
module f2s_checker import f2s_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            pixel_ready,
	input logic            spike_valid,
	input logic            spike_ready,
	input logic [TS_W-1:0] spike_timestamp,
	input logic            spike_last
);

	// A spike beat that is not taken stays offered.
	a_spike_hold: assert property (@(posedge clk) disable iff (!arst_n)
		spike_valid && !spike_ready |=> spike_valid)
		else $error("spike beat dropped while stalled");

	// A stalled spike beat keeps its payload.
	a_spike_stable: assert property (@(posedge clk) disable iff (!arst_n)
		spike_valid && !spike_ready |=> $stable(spike_timestamp) && $stable(spike_last))
		else $error("spike payload changed while stalled");

	// No event is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !spike_valid)
		else $error("spike valid during reset");

	// The memory clearing pass holds off pixel beats right after reset.
	a_clear_pass: assert property (@(posedge clk) $rose(arst_n) |-> !pixel_ready)
		else $error("pixel beat taken before memories were cleared");

endmodule

bind frame_to_spike_event_encoder f2s_checker u_f2s_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pixel_ready     (pixel.ready),
	.spike_valid     (spike.valid),
	.spike_ready     (spike.ready),
	.spike_timestamp (spike.timestamp),
	.spike_last      (spike.last)
);
